// ===== design/isid_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types.
package isid_pkg;

  // Default store depth
  localparam int unsigned DEF_CAPACITY = 128;

  // Payload widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 8;

  // Operation kinds
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_DEL = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] STS_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DELETED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL    = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // latch value, restart scan at entry zero
    logic scan;    // step the search one entry
    logic shift;   // step the compaction one entry
    logic append;  // write value at the tail, bump count
    logic dec;     // drop count by one after compaction
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;        // current read entry equals the value
    logic scan_end;   // search ran past the last valid entry
    logic full;       // store holds CAPACITY entries
    logic shift_end;  // all later entries moved down
  } dp_sts_t;

endpackage

// ===== design/integer_set_insert_delete.sv =====
// Top level of the insertion-ordered integer set with add and delete.
// Usage:
//   Input channel (in_valid/in_ready, in_kind, in_value): one transaction
//   asks to add (kind 0) or delete (kind 1) a signed 32-bit value.
//   Result channel (out_valid/out_ready, out_status, out_count): one
//   transaction per input, carrying the status code and the count after
//   the operation.
// Timing:
//   One operation at a time. The search reads the entry store one entry per
//   cycle through its single read port, from the first entry up to a match
//   or past the last valid entry. A delete searches up to the match and
//   then moves every later entry down one per cycle.
//   The next input is taken the cycle after the result is registered.
// Reset:
//   Synchronous, active low; the set is emptied (count zero). No clearing
//   pass runs over the store; entries past the count are never used.
// Stall:
//   The result sits in an output register. A new input may be taken while
//   it waits; the following result holds in the controller until the
//   register frees.
module integer_set_insert_delete #(
  parameter int unsigned CAPACITY = isid_pkg::DEF_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic signed [isid_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [isid_pkg::STATUS_W-1:0]        out_status,
  output logic [isid_pkg::COUNT_W-1:0]         out_count
);

  import isid_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [CNT_W-1:0] count;

  isid_ctrl #(
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_count  (out_count),
    .cmd        (cmd),
    .sts        (sts),
    .count      (count)
  );

  isid_datapath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .value (in_value),
    .sts   (sts),
    .count (count)
  );

endmodule

// ===== design/isid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module isid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/isid_datapath.sv =====
// Datapath: entry store, fill count, scan/compaction index and compare.
module isid_datapath #(
  parameter int unsigned CAPACITY = isid_pkg::DEF_CAPACITY,
  parameter int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  isid_pkg::dp_cmd_t             cmd,
  input  logic [isid_pkg::VALUE_W-1:0]  value,
  output isid_pkg::dp_sts_t             sts,
  output logic [CNT_W-1:0]              count
);

  import isid_pkg::*;

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [CNT_W-1:0]   idx_r,    idx_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;

  logic               more;
  logic               hit;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] rd_data;

  // Entry store
  isid_ram #(
    .WIDTH  (VALUE_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Compare and status
  assign more = (idx_r < count_r);
  assign hit  = rd_vld_r && (rd_data == value_r);

  assign sts.hit       = hit;
  assign sts.scan_end  = !rd_vld_r && !more;
  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.shift_end = !rd_vld_r && !more;
  assign count         = count_r;

  // Write port: tail append or move one entry down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[ADDR_W-1:0];
    wr_data = value_r;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.shift && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r - ADDR_W'(1);
      wr_data = rd_data;
    end
  end

  // Index, read tracking and count
  always_comb begin
    idx_nxt    = idx_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = rd_vld_r;
    count_nxt  = count_r;
    if (cmd.load) begin
      idx_nxt    = '0;
      rd_vld_nxt = 1'b0;
    end else if (cmd.scan && hit) begin
      // compaction starts just past the match
      idx_nxt    = CNT_W'(rd_idx_r) + CNT_W'(1);
      rd_vld_nxt = 1'b0;
    end else if (cmd.scan || cmd.shift) begin
      rd_vld_nxt = more;
      rd_idx_nxt = idx_r[ADDR_W-1:0];
      if (more) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
    if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (cmd.load) begin
      value_r <= value;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + CNT_W'(1) ||
                      count_r == $past(count_r) - CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into a full store");
`endif

endmodule

// ===== design/isid_ctrl.sv =====
// Controller: operation sequencing, result status and output register.
module isid_ctrl #(
  parameter int unsigned CNT_W = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [isid_pkg::STATUS_W-1:0]  out_status,
  output logic [isid_pkg::COUNT_W-1:0]   out_count,
  output isid_pkg::dp_cmd_t              cmd,
  input  isid_pkg::dp_sts_t              sts,
  input  logic [CNT_W-1:0]               count
);

  import isid_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]          state_r,  state_nxt;
  logic                kind_r;
  logic [STATUS_W-1:0] sts_r,    sts_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                accept;
  logic                out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    sts_nxt       = sts_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          if (kind_r == KIND_ADD) begin
            sts_nxt   = STS_PRESENT;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end else if (sts.scan_end) begin
          state_nxt = ST_DONE;
          if (kind_r == KIND_DEL) begin
            sts_nxt = STS_ABSENT;
          end else if (sts.full) begin
            sts_nxt = STS_FULL;
          end else begin
            cmd.append = 1'b1;
            sts_nxt    = STS_ADDED;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_end) begin
          cmd.dec   = 1'b1;
          sts_nxt   = STS_DELETED;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operation kind, pending status and result payload
  always_ff @(posedge clk) begin
    sts_r <= sts_nxt;
    if (accept) begin
      kind_r <= in_kind;
    end
    if (state_r == ST_DONE && out_free) begin
      out_status_r <= sts_r;
      out_count_r  <= COUNT_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SCAN)
    else $error("accepted transaction did not start a scan");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished operation did not present a result");
`endif

endmodule
